// File: rtl/core/ttt_pkg.sv
// shared types and codes for the timer task table
// no dependencies
package ttt_pkg;

  localparam int DEF_TASK_SLOTS = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int FIRE_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] ACT_SCHEDULE   = 2'd0;
  localparam logic [1:0] ACT_UNSCHEDULE = 2'd1;
  localparam logic [1:0] ACT_TICK       = 2'd2;

  localparam logic [2:0] ST_SCHEDULED  = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_REMOVED    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_FIRED      = 3'd4;
  localparam logic [2:0] ST_NONE_FIRED = 3'd5;

  typedef struct packed {
    logic [31:0] trigger;
    logic [15:0] period;
    logic [31:0] ident;
  } ttt_entry_t;

  typedef struct packed {
    logic load;    // latch the input beat and reset walk pointers
    logic sched;   // store the new task (unless full) and post its result
    logic walk;    // run the table walk
    logic finish;  // post the final result and commit the count
  } ttt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_done;
  } ttt_stat_t;

endpackage

// File: rtl/core/ttt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/ttt_ctrl.sv
// sequencer for the timer task table: one beat at a time
// depends on ttt_pkg
module ttt_ctrl
  import ttt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] action,
  input  ttt_stat_t stat,
  output ttt_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCHED = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (action == ACT_SCHEDULE) begin
            state_next = S_SCHED;
          end else if (action == ACT_UNSCHEDULE || action == ACT_TICK) begin
            state_next = S_WALK;
          end
        end
      end
      S_SCHED: begin
        if (stat.out_free) begin
          cmd.sched  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/ttt_datapath.sv
// table storage, compacting walk and result register
// depends on ttt_pkg and ttt_ram
module ttt_datapath
  import ttt_pkg::*;
#(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  ttt_cmd_t    cmd,
  output ttt_stat_t   stat,
  input  logic [1:0]  action,
  input  logic [31:0] trigger_time,
  input  logic [15:0] repeat_delay,
  input  logic [31:0] remove_id,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] task_id,
  output logic        last
);

  localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);

  logic [1:0]        op;
  logic [31:0]       trig_r;
  logic [15:0]       delay_r;
  logic [31:0]       rid_r;
  logic [31:0]       now_r;
  logic [CW-1:0]     live_count;
  logic [31:0]       next_ident;
  logic [CW-1:0]     rd_ptr;
  logic [CW-1:0]     wr_ptr;
  logic              have;
  logic              pend_valid;
  logic [31:0]       pend_id;
  logic              found;
  logic [FIRE_W-1:0] fires;

  ttt_entry_t ent;
  ttt_entry_t walk_entry;
  ttt_entry_t ram_wdata;
  logic [AW-1:0] ram_waddr;
  logic ram_we;
  logic out_free;
  logic full;
  logic due;
  logic hit;
  logic stall;
  logic keep_write;
  logic issue;
  logic push_pend;

  assign out_free = !out_valid || out_ready;
  assign full     = (live_count == CW'(TASK_SLOTS));

  // per-entry decision on the word that came back from the ram
  assign due   = cmd.walk && have && (op == ACT_TICK) &&
                 (fires < FIRE_W'(MAX_RESULTS)) && (ent.trigger <= now_r);
  assign hit   = cmd.walk && have && (op == ACT_UNSCHEDULE) && !found &&
                 (ent.ident == rid_r);
  // a second fire needs the result register to take the one held back
  assign stall      = due && pend_valid && !out_free;
  assign push_pend  = due && pend_valid && out_free;
  assign keep_write = cmd.walk && have && !stall && !hit &&
                      !(due && ent.period == 16'd0);
  assign issue      = cmd.walk && !stall && (rd_ptr != live_count);

  assign stat.out_free  = out_free;
  assign stat.walk_done = (rd_ptr == live_count) && !have;

  always_comb begin
    walk_entry = ent;
    if (due) begin
      walk_entry.trigger = now_r + 32'(ent.period);
    end
  end

  always_comb begin
    if (cmd.sched) begin
      ram_we    = !full;
      ram_waddr = live_count[AW-1:0];
      ram_wdata = '{trigger: trig_r, period: delay_r, ident: next_ident};
    end else begin
      ram_we    = keep_write;
      ram_waddr = wr_ptr[AW-1:0];
      ram_wdata = walk_entry;
    end
  end

  ttt_ram #(
    .WIDTH ($bits(ttt_entry_t)),
    .DEPTH (TASK_SLOTS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (ent)
  );

  // beat payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= action;
      trig_r  <= trigger_time;
      delay_r <= repeat_delay;
      rid_r   <= remove_id;
      now_r   <= now_time;
    end
    if (due && !stall) begin
      pend_id <= ent.ident;
    end
  end

  // walk and table control
  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      next_ident <= 32'd1;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      have       <= 1'b0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      fires      <= '0;
    end else begin
      if (cmd.load) begin
        rd_ptr     <= '0;
        wr_ptr     <= '0;
        have       <= 1'b0;
        pend_valid <= 1'b0;
        found      <= 1'b0;
        fires      <= '0;
      end
      if (cmd.sched && !full) begin
        live_count <= live_count + CW'(1);
        next_ident <= next_ident + 32'd1;
      end
      if (cmd.walk) begin
        if (issue) begin
          rd_ptr <= rd_ptr + CW'(1);
        end
        have <= issue || (have && stall);
        if (keep_write) begin
          wr_ptr <= wr_ptr + CW'(1);
        end
        if (due && !stall) begin
          fires      <= fires + FIRE_W'(1);
          pend_valid <= 1'b1;
        end
        if (hit) begin
          found <= 1'b1;
        end
      end
      // survivors were packed to the front
      if (cmd.finish) begin
        live_count <= wr_ptr;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.sched || push_pend || cmd.finish) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sched) begin
      status  <= full ? ST_FULL : ST_SCHEDULED;
      task_id <= full ? 32'd0 : next_ident;
      last    <= 1'b1;
    end else if (push_pend) begin
      status  <= ST_FIRED;
      task_id <= pend_id;
      last    <= 1'b0;
    end else if (cmd.finish) begin
      last <= 1'b1;
      if (op == ACT_TICK) begin
        status  <= pend_valid ? ST_FIRED : ST_NONE_FIRED;
        task_id <= pend_valid ? pend_id : 32'd0;
      end else begin
        status  <= found ? ST_REMOVED : ST_NOT_FOUND;
        task_id <= found ? rid_r : 32'd0;
      end
    end
  end

endmodule

// File: rtl/core/timer_task_table.sv
// timer task table: ordered one-shot and periodic tasks in a single ram
// schedule: the beat is latched, then the task is stored and its result posted once the result
// register is free; unschedule and tick walk the live entries one per cycle behind the registered
// ram read, then post the final result and commit the count once the result register is free;
// tick fires are posted during the walk, each held back until the next, a held output adds stalls
// reset: table empty, ids start at one; table ram is not cleared
module timer_task_table
  import ttt_pkg::*;
#(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] trigger_time,
  input  logic [15:0] repeat_delay,
  input  logic [31:0] remove_id,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] task_id,
  output logic        last
);

  ttt_cmd_t  cmd;
  ttt_stat_t stat;

  ttt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .stat     (stat),
    .cmd      (cmd)
  );

  ttt_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .trigger_time (trigger_time),
    .repeat_delay (repeat_delay),
    .remove_id    (remove_id),
    .now_time     (now_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .task_id      (task_id),
    .last         (last)
  );

endmodule

// File: verif/ttt_checker.sv
// result checker for the timer task table: tracks the task table from the input beats
// and compares every output beat in order; depends on ttt_pkg
module ttt_checker
  import ttt_pkg::*;
#(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] trigger_time,
  input  logic [15:0] repeat_delay,
  input  logic [31:0] remove_id,
  input  logic [31:0] now_time,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [31:0] task_id,
  input  logic        last,
  output int          fail_count,
  output int          pending_results,
  output int          beats_seen,
  output int          fires_seen,
  output int          full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] task_id;
    logic        last;
  } reply_t;

  reply_t      awaited_results[$];
  logic [31:0] slot_trigger[TASK_SLOTS];
  logic [15:0] slot_period[TASK_SLOTS];
  logic [31:0] slot_ident[TASK_SLOTS];
  int unsigned live = 0;
  logic [31:0] next_ident = 32'd1;
  int          fails = 0;
  int          beats = 0;
  int          fires = 0;
  int          fulls = 0;

  function automatic reply_t reply(input logic [2:0] st, input logic [31:0] id,
                                   input logic lst);
    reply_t r;
    r.status  = st;
    r.task_id = id;
    r.last    = lst;
    return r;
  endfunction

  // remove one task and close the gap so table order is kept
  task automatic drop_slot(input int unsigned pos);
    int unsigned j;
    for (j = pos; j + 1 < live; j++) begin
      slot_trigger[j] = slot_trigger[j + 1];
      slot_period[j]  = slot_period[j + 1];
      slot_ident[j]   = slot_ident[j + 1];
    end
    if (live > 0) live--;
  endtask

  task automatic table_step(input logic [1:0] act, input logic [31:0] trig,
                            input logic [15:0] dly, input logic [31:0] rid,
                            input logic [31:0] now_v);
    int unsigned i;
    int          n;
    logic        hit;
    reply_t      tail;
    case (act)
      ACT_SCHEDULE: begin
        if (live >= TASK_SLOTS) begin
          awaited_results.push_back(reply(ST_FULL, 32'd0, 1'b1));
          fulls++;
        end else begin
          slot_trigger[live] = trig;
          slot_period[live]  = dly;
          slot_ident[live]   = next_ident;
          live++;
          awaited_results.push_back(reply(ST_SCHEDULED, next_ident, 1'b1));
          next_ident = next_ident + 32'd1;
        end
      end
      ACT_UNSCHEDULE: begin
        hit = 1'b0;
        for (i = 0; i < live && !hit; i++) begin
          if (slot_ident[i] == rid) begin
            drop_slot(i);
            awaited_results.push_back(reply(ST_REMOVED, rid, 1'b1));
            hit = 1'b1;
          end
        end
        if (!hit) awaited_results.push_back(reply(ST_NOT_FOUND, 32'd0, 1'b1));
      end
      ACT_TICK: begin
        i = 0;
        n = 0;
        while (i < live && n < MAX_RESULTS) begin
          if (slot_trigger[i] <= now_v) begin
            awaited_results.push_back(reply(ST_FIRED, slot_ident[i], 1'b0));
            n++;
            fires++;
            if (slot_period[i] != 16'd0) begin
              slot_trigger[i] = now_v + {16'd0, slot_period[i]};
              i++;
            end else begin
              drop_slot(i);
            end
          end else begin
            i++;
          end
        end
        if (n == 0) begin
          awaited_results.push_back(reply(ST_NONE_FIRED, 32'd0, 1'b1));
        end else begin
          tail = awaited_results.pop_back();
          tail.last = 1'b1;
          awaited_results.push_back(tail);
        end
      end
      default: ;  // unused action code: no result, no change
    endcase
  endtask

  always @(posedge clk) begin : watch
    reply_t got;
    reply_t want;
    if (rst) begin
      awaited_results.delete();
      live = 0;
      next_ident = 32'd1;
    end else begin
      // results first: a result on this edge cannot belong to a beat taken on it
      if (out_valid && out_ready) begin
        got = reply(status, task_id, last);
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d task_id %0d last %0d",
                 got.status, got.task_id, got.last);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            fails++;
          end
          if (got.task_id !== want.task_id) begin
            $error("task_id mismatch: expected %0d, actual %0d",
                   want.task_id, got.task_id);
            fails++;
          end
          if (got.last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        beats++;
        table_step(action, trigger_time, repeat_delay, remove_id, now_time);
      end
    end
    fail_count      <= fails;
    pending_results <= awaited_results.size();
    beats_seen      <= beats;
    fires_seen      <= fires;
    full_seen       <= fulls;
  end

endmodule

// File: verif/tb_timer_task_table.sv
// testbench top for the timer task table: drives schedule, unschedule and tick beats
// with random idling on both sides; depends on ttt_pkg, timer_task_table, ttt_checker
module tb_timer_task_table;
  import ttt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         ITEM_COUNT = 460;
  localparam int         HOLD_CYCLES = 300;
  localparam int         STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] trigger_time;
  logic [15:0] repeat_delay;
  logic [31:0] remove_id;
  logic [31:0] now_time;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [31:0] task_id;
  logic        last;

  int          fail_count;
  int          pending_results;
  int          beats_seen;
  int          fires_seen;
  int          full_seen;

  int          beats_sent = 0;
  int unsigned ids_issued = 0;
  logic [31:0] now_t = 32'd0;
  bit          hold_request = 1'b0;
  int          stall_cycles = 0;

  timer_task_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .trigger_time(trigger_time), .repeat_delay(repeat_delay),
    .remove_id(remove_id), .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .task_id(task_id), .last(last)
  );

  ttt_checker check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .trigger_time(trigger_time), .repeat_delay(repeat_delay),
    .remove_id(remove_id), .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .task_id(task_id), .last(last),
    .fail_count(fail_count), .pending_results(pending_results),
    .beats_seen(beats_seen), .fires_seen(fires_seen), .full_seen(full_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one beat; valid stays up after acceptance unless a gap follows
  task automatic offer(input logic [1:0] act, input logic [31:0] trig,
                       input logic [15:0] dly, input logic [31:0] rid,
                       input logic [31:0] now_v);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    trigger_time <= trig;
    repeat_delay <= dly;
    remove_id    <= rid;
    now_time     <= now_v;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (act == ACT_SCHEDULE) ids_issued++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    @(posedge clk);
  endtask

  task automatic directed_beats();
    int k;
    logic [31:0] trig;
    logic [15:0] dly;
    offer(ACT_TICK, $urandom, 16'($urandom), $urandom, 32'h0);        // empty table
    offer(ACT_UNSCHEDULE, $urandom, 16'($urandom), 32'h0, $urandom);  // id never issued
    offer(ACT_UNUSED, $urandom, 16'($urandom), $urandom, $urandom);
    offer(ACT_SCHEDULE, 32'h0, 16'h0, $urandom, $urandom);
    offer(ACT_TICK, $urandom, 16'($urandom), $urandom, 32'h0);        // one-shot at time zero
    for (k = 0; k < 16; k++) begin
      if (k == 0) trig = 32'hFFFF_FFFF;
      else if (k == 1) trig = 32'h0;
      else trig = $urandom_range(0, 1000);
      if (k == 1) dly = 16'hFFFF;
      else if (k % 2 == 0) dly = 16'h0;
      else dly = 16'($urandom_range(1, 500));
      offer(ACT_SCHEDULE, trig, dly, $urandom, $urandom);
    end
    offer(ACT_SCHEDULE, $urandom, 16'($urandom), $urandom, $urandom);  // table full
    // every task due, periodic re-arm wraps past the top of the time range
    offer(ACT_TICK, $urandom, 16'($urandom), $urandom, 32'hFFFF_FFFF);
    offer(ACT_UNSCHEDULE, $urandom, 16'($urandom), 32'd3, $urandom);
    offer(ACT_UNSCHEDULE, $urandom, 16'($urandom), 32'hFFFF_FFFF, $urandom);
    offer(ACT_TICK, $urandom, 16'($urandom), $urandom, 32'd600);
  endtask

  task automatic random_beat();
    int          pick;
    int          r;
    logic [1:0]  act;
    logic [31:0] trig;
    logic [15:0] dly;
    logic [31:0] rid;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      act = 2'($urandom_range(0, 3));
      offer(act, $urandom, 16'($urandom), $urandom, $urandom);
    end else if (pick < 41) begin
      r = $urandom_range(0, 99);
      if (r < 70) dly = 16'h0;
      else if (r < 92) dly = 16'($urandom_range(1, 200));
      else dly = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) < 88) trig = now_t + $urandom_range(0, 300);
      else trig = $urandom;
      offer(ACT_SCHEDULE, trig, dly, $urandom, $urandom);
    end else if (pick < 66) begin
      r = $urandom_range(0, 99);
      if (r < 50) rid = ids_issued - $urandom_range(0, 15);
      else if (r < 80) rid = $urandom_range(1, ids_issued);
      else rid = $urandom;
      offer(ACT_UNSCHEDULE, $urandom, 16'($urandom), rid, $urandom);
    end else begin
      now_t = now_t + $urandom_range(0, 120);
      offer(ACT_TICK, $urandom, 16'($urandom), $urandom, now_t);
    end
  endtask

  // receiver: random backpressure, plus one long hold-off on request
  initial begin : receiver
    int run;
    int gap;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_request && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        out_ready <= 1'b1;
        run = $urandom_range(1, 20);
        repeat (run) @(posedge clk);
        gap = idle_cycles();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat on either channel for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : sender
    int k;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    action       <= ACT_SCHEDULE;
    trigger_time <= 32'h0;
    repeat_delay <= 16'h0;
    remove_id    <= 32'h0;
    now_time     <= 32'h0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed_beats();
    now_t = 32'd1000;

    while (beats_sent < ITEM_COUNT) begin
      // burst of one-shots to push the table to full
      if (beats_sent % 70 == 0) begin
        for (k = 0; k < 18; k++)
          offer(ACT_SCHEDULE, now_t + $urandom_range(0, 50), 16'h0, $urandom, $urandom);
        now_t = now_t + 60;
        offer(ACT_TICK, $urandom, 16'($urandom), $urandom, now_t);
      end
      if (!hold_request && beats_sent >= 150) hold_request = 1'b1;
      if (beats_sent == 300) wait_drained();
      random_beat();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d input beats, %0d task fires, %0d schedules refused on a full table",
             beats_seen, fires_seen, full_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ttt_pkg.sv
rtl/core/ttt_ram.sv
rtl/core/ttt_ctrl.sv
rtl/core/ttt_datapath.sv
rtl/core/timer_task_table.sv
verif/ttt_checker.sv
verif/tb_timer_task_table.sv
